/* hw/rtl/umpq_pkg.sv */
// Shared definitions for the unsorted max priority queue.
// Holds the default capacity, result status codes and the controller/datapath bundles.
// No dependencies.
`default_nettype none

package umpq_pkg;

	localparam int unsigned CAPACITY_DEF = 16;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_EMPTY = 2'd1,
		ST_FULL  = 2'd2
	} status_t;

	localparam logic FUNC_INSERT = 1'b0;
	localparam logic FUNC_DELMAX = 1'b1;

	// controller -> datapath
	typedef struct packed {
		logic capture;     // latch request payload
		logic decide;      // pick result status, perform insert
		logic scan_start;  // read entry 0, reset scan pointers
		logic scan_step;   // compare one entry, read the next
		logic shift_start; // aim compaction at the slot after the winner
		logic shift_step;  // move one entry down by one slot
		logic res_load;    // load the result register
	} cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic is_del;
		logic empty;
		logic scan_last;
		logic shift_done;
		logic res_free;
	} stat_t;

endpackage

`default_nettype wire

/* hw/rtl/umpq_ctrl.sv */
// Sequencer for the unsorted max priority queue.
// Depends on umpq_pkg (cmd_t, stat_t).
`default_nettype none

module umpq_ctrl
	import umpq_pkg::*;
(
	input  wire   clk,
	input  wire   arst_n,
	input  wire   req_valid,
	output logic  req_stall,
	input  stat_t st,
	output cmd_t  cmd
);

	typedef enum logic [4:0] {
		S_IDLE  = 5'b00001,
		S_EXEC  = 5'b00010,
		S_SCAN  = 5'b00100,
		S_SHIFT = 5'b01000,
		S_FIN   = 5'b10000
	} state_t;

	state_t state_q, state_nx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	assign req_stall = (state_q != S_IDLE);

	always_comb begin
		state_nx = state_q;
		cmd      = '0;
		case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					cmd.capture = 1'b1;
					state_nx    = S_EXEC;
				end
			end
			S_EXEC: begin
				cmd.decide = 1'b1;
				if (st.is_del && !st.empty) begin
					cmd.scan_start = 1'b1;
					state_nx       = S_SCAN;
				end else begin
					state_nx = S_FIN;
				end
			end
			S_SCAN: begin
				cmd.scan_step = 1'b1;
				if (st.scan_last) begin
					cmd.shift_start = 1'b1;
					state_nx        = S_SHIFT;
				end
			end
			S_SHIFT: begin
				cmd.shift_step = 1'b1;
				if (st.shift_done) begin
					state_nx = S_FIN;
				end
			end
			S_FIN: begin
				if (st.res_free) begin
					cmd.res_load = 1'b1;
					state_nx     = S_IDLE;
				end
			end
			default: begin
				state_nx = S_IDLE;
			end
		endcase
	end

endmodule

`default_nettype wire

/* hw/rtl/umpq_dp.sv */
// Datapath for the unsorted max priority queue: entry memory, scan and
// compaction pointers, running maximum and result register.
// Depends on umpq_pkg.
`default_nettype none

module umpq_dp
	import umpq_pkg::*;
#(
	parameter int unsigned CAPACITY = CAPACITY_DEF
) (
	input  wire                clk,
	input  wire                arst_n,
	input  cmd_t               cmd,
	output stat_t              st,
	input  wire                func,
	input  wire signed [31:0]  value_in,
	input  wire signed [31:0]  prio_in,
	output logic               res_valid,
	input  wire                res_stall,
	output logic signed [31:0] value_out,
	output logic signed [31:0] prio_out,
	output logic [1:0]         status,
	output logic [4:0]         occupancy
);

	localparam int unsigned AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int unsigned CW = $clog2(CAPACITY + 1);

	logic [63:0]   mem [CAPACITY];
	logic [63:0]   rdata_s1;

	logic          func_q;
	logic [31:0]   val_q;
	logic [31:0]   prio_q;
	logic [CW-1:0] cnt_q;
	logic [CW-1:0] sp_q;
	logic [AW-1:0] cp_q;
	logic [AW-1:0] best_idx_q;
	logic [63:0]   best_q;
	logic [AW-1:0] wa_q;
	logic          wpend_q;
	status_t       st_q;

	logic          res_valid_q;
	logic [31:0]   res_val_q;
	logic [31:0]   res_prio_q;
	logic [1:0]    res_st_q;
	logic [CW-1:0] res_occ_q;
	logic [CW+4:0] occ_ext;

	logic          full;
	logic          empty;
	logic          take;
	logic [AW-1:0] best_idx_nx;
	logic          sp_in;
	logic          rd_en;
	logic [AW-1:0] rd_addr;
	logic          we;
	logic [AW-1:0] wr_addr;
	logic [63:0]   wr_data;
	logic          del_ok;

	assign full  = (cnt_q == CW'(CAPACITY));
	assign empty = (cnt_q == '0);
	assign sp_in = (sp_q < cnt_q);

	// first entry seeds the maximum; later ones win only on strictly larger priority
	assign take = (cp_q == '0) || ($signed(rdata_s1[63:32]) > $signed(best_q[63:32]));
	assign best_idx_nx = take ? cp_q : best_idx_q;

	always_comb begin
		rd_en   = 1'b0;
		rd_addr = sp_q[AW-1:0];
		if (cmd.scan_start) begin
			rd_en   = 1'b1;
			rd_addr = '0;
		end else if ((cmd.scan_step || cmd.shift_step) && sp_in) begin
			rd_en = 1'b1;
		end
	end

	always_comb begin
		we      = 1'b0;
		wr_addr = wa_q;
		wr_data = rdata_s1;
		if (cmd.decide && (func_q == FUNC_INSERT) && !full) begin
			we      = 1'b1;
			wr_addr = cnt_q[AW-1:0];
			wr_data = {prio_q, val_q};
		end else if (cmd.shift_step && wpend_q) begin
			we = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rdata_s1 <= mem[rd_addr];
		end
	end

	// payload and scan registers
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			func_q <= func;
			val_q  <= value_in;
			prio_q <= prio_in;
		end
		if (cmd.decide) begin
			if (func_q == FUNC_DELMAX) begin
				st_q <= empty ? ST_EMPTY : ST_OK;
			end else begin
				st_q <= full ? ST_FULL : ST_OK;
			end
		end
		if (cmd.scan_start) begin
			sp_q <= CW'(1);
			cp_q <= '0;
		end else if (cmd.scan_step) begin
			if (take) begin
				best_q <= rdata_s1;
			end
			best_idx_q <= best_idx_nx;
			cp_q       <= cp_q + AW'(1);
			if (cmd.shift_start) begin
				sp_q <= CW'(best_idx_nx) + CW'(1);
			end else begin
				sp_q <= sp_q + CW'(1);
			end
		end else if (cmd.shift_step && sp_in) begin
			wa_q <= AW'(sp_q - CW'(1));
			sp_q <= sp_q + CW'(1);
		end
	end

	assign del_ok = (func_q == FUNC_DELMAX) && (st_q == ST_OK);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q       <= '0;
			wpend_q     <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			if (cmd.decide && (func_q == FUNC_INSERT) && !full) begin
				cnt_q <= cnt_q + CW'(1);
			end else if (cmd.res_load && del_ok) begin
				cnt_q <= cnt_q - CW'(1);
			end
			if (cmd.shift_start) begin
				wpend_q <= 1'b0;
			end else if (cmd.shift_step) begin
				wpend_q <= sp_in;
			end
			if (cmd.res_load) begin
				res_valid_q <= 1'b1;
			end else if (!res_stall) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.res_load) begin
			res_val_q  <= del_ok ? best_q[31:0] : '0;
			res_prio_q <= del_ok ? best_q[63:32] : '0;
			res_st_q   <= st_q;
			res_occ_q  <= del_ok ? (cnt_q - CW'(1)) : cnt_q;
		end
	end

	assign occ_ext   = (CW + 5)'(res_occ_q);
	assign res_valid = res_valid_q;
	assign value_out = res_val_q;
	assign prio_out  = res_prio_q;
	assign status    = res_st_q;
	assign occupancy = occ_ext[4:0];

	assign st.is_del     = (func_q == FUNC_DELMAX);
	assign st.empty      = empty;
	assign st.scan_last  = (CW'(cp_q) == (cnt_q - CW'(1)));
	assign st.shift_done = !sp_in && !wpend_q;
	assign st.res_free   = !res_valid_q || !res_stall;

endmodule

`default_nettype wire

/* hw/rtl/unsorted_max_priority_queue.sv */
// Unsorted max priority queue, top level; depends on umpq_pkg, umpq_ctrl, umpq_dp.
// Insert, and delete on an empty queue, go through capture, decide and result load.
// Delete-max on N held entries scans all N entries with one memory read per cycle,
// then entries behind the winner move down one per cycle.
// One request at a time; the next is taken once the result sits in the output register.
// Reset (arst_n low) empties the queue and drops any pending result; memory is not cleared.
`default_nettype none

module unsorted_max_priority_queue
	import umpq_pkg::*;
#(
	parameter int unsigned CAPACITY = CAPACITY_DEF
) (
	input  wire                clk,
	input  wire                arst_n,
	// request channel
	input  wire                req_valid,
	output logic               req_stall,
	input  wire                func,
	input  wire signed [31:0]  value_in,
	input  wire signed [31:0]  prio_in,
	// result channel
	output logic               res_valid,
	input  wire                res_stall,
	output logic signed [31:0] value_out,
	output logic signed [31:0] prio_out,
	output logic [1:0]         status,
	output logic [4:0]         occupancy
);

	cmd_t  cmd;
	stat_t st;

	// Controller: sequence capture, decide, scan, compaction and result load.
	umpq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.st        (st),
		.cmd       (cmd)
	);

	// Datapath: hold entries in arrival order, track the running maximum
	// (earliest wins on ties), close the gap, and hold the result until taken.
	umpq_dp #(
		.CAPACITY (CAPACITY)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.st        (st),
		.func      (func),
		.value_in  (value_in),
		.prio_in   (prio_in),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.value_out (value_out),
		.prio_out  (prio_out),
		.status    (status),
		.occupancy (occupancy)
	);

endmodule

`default_nettype wire
